### rtl/core/adc_ladder_button_event_fsm_top_defines.svh
`ifndef ADC_LADDER_BUTTON_EVENT_FSM_TOP_DEFINES_SVH
`define ADC_LADDER_BUTTON_EVENT_FSM_TOP_DEFINES_SVH

// checked only out of reset
`define ALBEF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// checked during reset too
`define ALBEF_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

### rtl/core/albef_pkg.sv
package albef_pkg;

  localparam int LEVEL_W  = 13;
  localparam int MARGIN_W = 10;
  localparam int DEB_W    = 8;
  localparam int INTV_W   = 16;
  localparam int KEY_W    = 3;
  localparam int EVENT_W  = 3;
  localparam int REPEAT_W = 4;
  localparam int ADDR_W   = 5;
  localparam int DATA_W   = 32;
  localparam int MAX_WIN  = 4;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef logic [LEVEL_W-1:0] level_t;
  typedef logic [KEY_W-1:0]   key_t;

  localparam level_t KEY_CENTER_RST [MAX_WIN] = '{13'd10, 13'd335, 13'd995, 13'd674};
  localparam logic [MARGIN_W-1:0] MARGIN_RST = 10'd100;
  localparam logic [DEB_W-1:0]    DEB_RST    = 8'd2;
  localparam logic [INTV_W-1:0]   LONG_RST   = 16'd75;
  localparam logic [INTV_W-1:0]   DOUBLE_RST = 16'd10;

  localparam logic [2:0] REG_KEY1   = 3'd0;
  localparam logic [2:0] REG_MARGIN = 3'd4;
  localparam logic [2:0] REG_DEB    = 3'd5;
  localparam logic [2:0] REG_LONG   = 3'd6;
  localparam logic [2:0] REG_DOUBLE = 3'd7;

  localparam key_t KEY_NONE = 3'd0;

  typedef enum logic [EVENT_W-1:0] {
    EV_NONE       = 3'd0,
    EV_SHORT_DOWN = 3'd1,
    EV_SHORT_UP   = 3'd2,
    EV_LONG_START = 3'd3,
    EV_LONG_HOLD  = 3'd4,
    EV_LONG_UP    = 3'd5
  } event_e;

  typedef struct packed {
    logic [DEB_W-1:0]  debounce_lim;
    logic [INTV_W-1:0] long_lim;
    logic [INTV_W-1:0] double_interval_ticks;
  } timing_cfg_t;

  typedef struct packed {
    logic valid;
    key_t seen;
  } key_item_t;

endpackage

### rtl/core/albef_front.sv
module albef_front #(
  parameter int NUM_WIN = 4
) (
  input  albef_pkg::level_t                  adc_level_i,
  input  albef_pkg::level_t                  key_center_i [NUM_WIN],
  input  logic [albef_pkg::MARGIN_W-1:0]     window_margin_i,
  output albef_pkg::key_t                    key_seen_o
);

  localparam int SUM_W = albef_pkg::LEVEL_W + 1;

  logic [SUM_W-1:0] level_plus;
  logic [SUM_W-1:0] center_plus [NUM_WIN];
  logic [SUM_W-1:0] center_ext  [NUM_WIN];
  logic [NUM_WIN-1:0] hit;

  always_comb begin
    level_plus = SUM_W'(adc_level_i) + SUM_W'(window_margin_i);
    for (int i = 0; i < NUM_WIN; i++) begin
      center_ext[i]  = SUM_W'(key_center_i[i]);
      center_plus[i] = SUM_W'(key_center_i[i]) + SUM_W'(window_margin_i);
      hit[i] = (level_plus >= center_ext[i]) && (SUM_W'(adc_level_i) <= center_plus[i]);
    end
  end

  // first window wins
  always_comb begin
    key_seen_o = albef_pkg::KEY_NONE;
    for (int i = NUM_WIN - 1; i >= 0; i--) begin
      if (hit[i]) begin
        key_seen_o = albef_pkg::KEY_W'(i + 1);
      end
    end
  end

endmodule

### rtl/core/albef_queue.sv
module albef_queue (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  albef_pkg::key_t       push_seen_i,
  input  logic                  pop_i,
  output logic                  full_o,
  output albef_pkg::key_item_t  head_o
);

  albef_pkg::key_t                  mem_q [albef_pkg::QUEUE_DEPTH];
  logic [albef_pkg::QPTR_W-1:0]     rd_ptr_q, rd_ptr_d;
  logic [albef_pkg::QPTR_W-1:0]     wr_ptr_q, wr_ptr_d;
  logic [albef_pkg::QCNT_W-1:0]     count_q, count_d;
  logic                             do_push;
  logic                             do_pop;

  assign full_o       = (count_q == albef_pkg::QCNT_W'(albef_pkg::QUEUE_DEPTH));
  assign head_o.valid = (count_q != '0);
  assign head_o.seen  = mem_q[rd_ptr_q];

  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && head_o.valid;

  always_comb begin
    rd_ptr_d = rd_ptr_q;
    wr_ptr_d = wr_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == albef_pkg::QPTR_W'(albef_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                              : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == albef_pkg::QPTR_W'(albef_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                              : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_ptr_q <= '0;
      wr_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      rd_ptr_q <= rd_ptr_d;
      wr_ptr_q <= wr_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_seen_i;
    end
  end

endmodule

### rtl/core/albef_back.sv
module albef_back #(
  parameter int TICK_BITS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  albef_pkg::key_item_t          head_i,
  output logic                          pop_o,
  input  albef_pkg::timing_cfg_t        cfg_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [albef_pkg::EVENT_W-1:0] event_res_o,
  output logic                          event_fired_o,
  output logic                          dbl_press_o,
  output albef_pkg::key_t               pressed_key_o,
  output albef_pkg::key_t               key_seen_o
);

  localparam int CMP_W = (TICK_BITS > albef_pkg::INTV_W) ? TICK_BITS : albef_pkg::INTV_W;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DEBOUNCE,
    ST_PRESSED,
    ST_LONG
  } state_e;

  state_e                            state_q, state_d;
  logic [TICK_BITS-1:0]              tick_q, tick_d;
  logic [albef_pkg::REPEAT_W-1:0]    repeat_q, repeat_d;
  logic [albef_pkg::INTV_W-1:0]      window_q, window_d;
  albef_pkg::key_t                   held_q, held_d;
  albef_pkg::event_e                 event_q, event_d;
  albef_pkg::key_t                   code_q, code_d;
  logic                              fired_d;
  logic                              dbl_d;
  albef_pkg::key_t                   seen;

  logic                              out_valid_q;
  logic                              fired_q;
  logic                              dbl_q;
  albef_pkg::key_t                   seen_q;

  assign seen  = head_i.seen;
  assign pop_o = head_i.valid && (!out_valid_q || !out_stall_i);

  always_comb begin
    state_d  = state_q;
    tick_d   = tick_q;
    repeat_d = repeat_q;
    window_d = window_q;
    held_d   = held_q;
    event_d  = event_q;
    code_d   = code_q;
    fired_d  = 1'b0;
    dbl_d    = 1'b0;

    if (state_q != ST_IDLE) begin
      if (!(&tick_q)) begin
        tick_d = tick_q + 1'b1;
      end
    end else if (window_q != '0) begin
      window_d = window_q - 1'b1;
      if (window_d == '0) begin
        repeat_d = '0;
      end
    end

    case (state_q)
      ST_IDLE: begin
        if (seen != albef_pkg::KEY_NONE) begin
          tick_d  = '0;
          state_d = ST_DEBOUNCE;
          held_d  = seen;
        end else begin
          event_d = albef_pkg::EV_NONE;
        end
      end
      ST_DEBOUNCE: begin
        if (seen == held_q) begin
          if (CMP_W'(tick_d) >= CMP_W'(cfg_i.debounce_lim)) begin
            code_d   = seen;
            event_d  = albef_pkg::EV_SHORT_DOWN;
            fired_d  = 1'b1;
            state_d  = ST_PRESSED;
            repeat_d = repeat_d + 1'b1;
            dbl_d    = (repeat_d == albef_pkg::REPEAT_W'(2));
            window_d = cfg_i.double_interval_ticks;
          end
        end else begin
          event_d = albef_pkg::EV_NONE;
          state_d = ST_IDLE;
        end
      end
      ST_PRESSED: begin
        if (seen == held_q) begin
          if (CMP_W'(tick_d) >= CMP_W'(cfg_i.long_lim)) begin
            event_d  = albef_pkg::EV_LONG_START;
            fired_d  = 1'b1;
            repeat_d = '0;
            window_d = '0;
            state_d  = ST_LONG;
          end
        end else begin
          event_d = (event_q == albef_pkg::EV_SHORT_DOWN) ? albef_pkg::EV_SHORT_UP
                                                          : albef_pkg::EV_LONG_UP;
          fired_d = 1'b1;
          state_d = ST_IDLE;
        end
      end
      ST_LONG: begin
        if (seen == held_q) begin
          if (CMP_W'(tick_d) >= CMP_W'(cfg_i.long_lim)) begin
            event_d  = albef_pkg::EV_LONG_HOLD;
            fired_d  = 1'b1;
            repeat_d = '0;
            window_d = '0;
          end
        end else begin
          event_d = albef_pkg::EV_LONG_UP;
          fired_d = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      tick_q      <= '0;
      repeat_q    <= '0;
      window_q    <= '0;
      held_q      <= albef_pkg::KEY_NONE;
      event_q     <= albef_pkg::EV_NONE;
      code_q      <= albef_pkg::KEY_W'(1);
      out_valid_q <= 1'b0;
      fired_q     <= 1'b0;
      dbl_q       <= 1'b0;
      seen_q      <= albef_pkg::KEY_NONE;
    end else if (pop_o) begin
      state_q     <= state_d;
      tick_q      <= tick_d;
      repeat_q    <= repeat_d;
      window_q    <= window_d;
      held_q      <= held_d;
      event_q     <= event_d;
      code_q      <= code_d;
      out_valid_q <= 1'b1;
      fired_q     <= fired_d;
      dbl_q       <= dbl_d;
      seen_q      <= seen;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign event_res_o   = event_q;
  assign event_fired_o = fired_q;
  assign dbl_press_o   = dbl_q;
  assign pressed_key_o = code_q;
  assign key_seen_o    = seen_q;

endmodule

### rtl/core/adc_ladder_button_event_fsm_top.sv
// Resistor-ladder button decoder: each accepted transaction is one scan tick's calibrated
// reading; the block matches it against the key windows and steps the press machine,
// returning one result transaction per tick. A transaction is taken every clock unless the
// queue is full; window matches enter a two-entry queue, and the press machine writes its
// result into the output register; the queue lets input go on while a result is stalled.
// Users write registers over the APB port only while no tick is in flight; not enforced.
`include "adc_ladder_button_event_fsm_top_defines.svh"

module adc_ladder_button_event_fsm_top #(
  parameter int NUM_KEYS  = 4,
  parameter int TICK_BITS = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [albef_pkg::LEVEL_W-1:0]     adc_level_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [albef_pkg::EVENT_W-1:0]     event_res_o,
  output logic                              event_fired_o,
  output logic                              dbl_press_o,
  output logic [albef_pkg::KEY_W-1:0]       pressed_key_o,
  output logic [albef_pkg::KEY_W-1:0]       key_seen_o,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [albef_pkg::ADDR_W-1:0]      paddr,
  input  logic [albef_pkg::DATA_W-1:0]      pwdata,
  output logic [albef_pkg::DATA_W-1:0]      prdata,
  output logic                              pready
);

  localparam int NUM_WIN = (NUM_KEYS < albef_pkg::MAX_WIN) ? NUM_KEYS : albef_pkg::MAX_WIN;

  albef_pkg::level_t                  center_q [NUM_WIN];
  logic [albef_pkg::MARGIN_W-1:0]     margin_q;
  albef_pkg::timing_cfg_t             timing_q;
  logic                               cfg_wr;
  logic [2:0]                         reg_idx;

  albef_pkg::key_t                    front_seen;
  albef_pkg::key_item_t               head;
  logic                               pop;
  logic                               q_full;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign reg_idx = paddr[4:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_WIN; i++) begin
        center_q[i] <= albef_pkg::KEY_CENTER_RST[i];
      end
      margin_q                       <= albef_pkg::MARGIN_RST;
      timing_q.debounce_lim          <= albef_pkg::DEB_RST;
      timing_q.long_lim              <= albef_pkg::LONG_RST;
      timing_q.double_interval_ticks <= albef_pkg::DOUBLE_RST;
    end else if (cfg_wr) begin
      for (int i = 0; i < NUM_WIN; i++) begin
        if (reg_idx == 3'(albef_pkg::REG_KEY1 + i)) begin
          center_q[i] <= pwdata[albef_pkg::LEVEL_W-1:0];
        end
      end
      case (reg_idx)
        albef_pkg::REG_MARGIN: margin_q <= pwdata[albef_pkg::MARGIN_W-1:0];
        albef_pkg::REG_DEB:    timing_q.debounce_lim <= pwdata[albef_pkg::DEB_W-1:0];
        albef_pkg::REG_LONG:   timing_q.long_lim <= pwdata[albef_pkg::INTV_W-1:0];
        albef_pkg::REG_DOUBLE: timing_q.double_interval_ticks <= pwdata[albef_pkg::INTV_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    for (int i = 0; i < NUM_WIN; i++) begin
      if (reg_idx == 3'(albef_pkg::REG_KEY1 + i)) begin
        prdata = albef_pkg::DATA_W'(center_q[i]);
      end
    end
    case (reg_idx)
      albef_pkg::REG_MARGIN: prdata = albef_pkg::DATA_W'(margin_q);
      albef_pkg::REG_DEB:    prdata = albef_pkg::DATA_W'(timing_q.debounce_lim);
      albef_pkg::REG_LONG:   prdata = albef_pkg::DATA_W'(timing_q.long_lim);
      albef_pkg::REG_DOUBLE: prdata = albef_pkg::DATA_W'(timing_q.double_interval_ticks);
      default: begin
      end
    endcase
  end

  albef_front #(
    .NUM_WIN(NUM_WIN)
  ) u_front (
    .adc_level_i    (adc_level_i),
    .key_center_i   (center_q),
    .window_margin_i(margin_q),
    .key_seen_o     (front_seen)
  );

  assign in_stall_o = q_full;

  albef_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (in_valid_i),
    .push_seen_i(front_seen),
    .pop_i      (pop),
    .full_o     (q_full),
    .head_o     (head)
  );

  albef_back #(
    .TICK_BITS(TICK_BITS)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .head_i        (head),
    .pop_o         (pop),
    .cfg_i         (timing_q),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .event_res_o   (event_res_o),
    .event_fired_o (event_fired_o),
    .dbl_press_o   (dbl_press_o),
    .pressed_key_o (pressed_key_o),
    .key_seen_o    (key_seen_o)
  );

  `ALBEF_ASSERT(a_double_is_short_down, out_valid_o && dbl_press_o |-> event_fired_o && event_res_o == albef_pkg::EV_SHORT_DOWN, "double click without short down")
  `ALBEF_ASSERT(a_fired_has_event, out_valid_o && event_fired_o |-> event_res_o != albef_pkg::EV_NONE, "event fired with no event")
  `ALBEF_ASSERT(a_key_code_nonzero, out_valid_o |-> pressed_key_o != albef_pkg::KEY_NONE, "pressed key code is zero")
  `ALBEF_ASSERT_ALWAYS(a_full_means_blocked, in_stall_o |-> out_valid_o, "queue full while output empty")

endmodule
